/* sv/psp_pkg.sv */
// ----------------------------------------------------------------------------
// psp_pkg
// The shared field width constant and controller/datapath command and status types for the
// price span and profit tracker.
// ----------------------------------------------------------------------------
package psp_pkg;

  localparam int FIELD_W = 32;

  typedef struct packed {
    logic load_in;
    logic rd_top;
    logic pop;
    logic push;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic top_le;
    logic more;
  } stat_t;

endpackage

/* sv/psp_in_if.sv */
// ----------------------------------------------------------------------------
// psp_in_if
// Price channel: valid/ready handshake carrying one price per item.
// ----------------------------------------------------------------------------
interface psp_in_if;
  logic                         valid;
  logic                         ready;
  logic [psp_pkg::FIELD_W-1:0]  price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

/* sv/psp_out_if.sv */
// ----------------------------------------------------------------------------
// psp_out_if
// Result channel: valid/ready handshake carrying span and profit statistics.
// ----------------------------------------------------------------------------
interface psp_out_if;
  logic                         valid;
  logic                         ready;
  logic [psp_pkg::FIELD_W-1:0]  span;
  logic [psp_pkg::FIELD_W-1:0]  best_profit;
  logic [psp_pkg::FIELD_W-1:0]  buy_day;
  logic [psp_pkg::FIELD_W-1:0]  sell_day;
  logic                         trade_found;
  logic [psp_pkg::FIELD_W-1:0]  lowest_price;
  logic [psp_pkg::FIELD_W-1:0]  highest_price;
  logic                         stack_overflowed;

  modport source (output valid, output span, output best_profit, output buy_day,
                  output sell_day, output trade_found, output lowest_price,
                  output highest_price, output stack_overflowed, input ready);
  modport sink   (input valid, input span, input best_profit, input buy_day,
                  input sell_day, input trade_found, input lowest_price,
                  input highest_price, input stack_overflowed, output ready);
endinterface

/* sv/price_span_profit_tracker_unit.sv */
// ----------------------------------------------------------------------------
// price_span_profit_tracker_unit
// Stock span and best buy-then-sell profit tracker over a stream of prices.
//
// Usage:
//   prices  : one unsigned fixed-point price per item (low PRICE_WIDTH bits).
//   results : one item per price with the span, best profit, buy and sell
//             days, trade flag, running min and max, and the sticky stack
//             overflow flag.
//   Sequence: a price is taken, the span stack is popped while its top
//             price is not above the new price, the new entry is pushed,
//             and the result is loaded into the output register; the span
//             stack RAM has one read port, so pops are done one at a time.
//   Stack   : circular RAM of STACK_DEPTH entries; when full, a push
//             overwrites the oldest entry and sets the overflow flag.
//   Reset   : rst (synchronous) empties the stack and clears all statistics;
//             the RAM needs no clearing pass.
//   Stall   : the result waits in its output register; the next price is
//             taken and processed, then held until the register is free.
// ----------------------------------------------------------------------------
module price_span_profit_tracker_unit #(
  parameter int STACK_DEPTH = 1024,
  parameter int PRICE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  psp_in_if.sink     prices,
  psp_out_if.source  results
);
  import psp_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  psp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prices.valid),
    .in_ready  (prices.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  psp_datapath #(.STACK_DEPTH(STACK_DEPTH), .PRICE_WIDTH(PRICE_WIDTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .price_in     (prices.price),
    .span_out     (results.span),
    .profit_out   (results.best_profit),
    .buy_out      (results.buy_day),
    .sell_out     (results.sell_day),
    .trade_out    (results.trade_found),
    .lowest_out   (results.lowest_price),
    .highest_out  (results.highest_price),
    .overflow_out (results.stack_overflowed)
  );

endmodule

/* sv/psp_ram.sv */
// ----------------------------------------------------------------------------
// psp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/psp_ctrl.sv */
// ----------------------------------------------------------------------------
// psp_ctrl
// Sequencer: accept a price, pop the span stack one entry per cycle, push,
// then hand the result to the output register.
// ----------------------------------------------------------------------------
module psp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  psp_pkg::stat_t  stat,
  output psp_pkg::ctrl_t  ctrl
);
  import psp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load_in = 1'b1;
          if (stat.empty) begin
            state_next = S_PUSH;
          end else begin
            ctrl.rd_top = 1'b1;
            state_next  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.top_le) begin
          ctrl.pop = 1'b1;
          if (!stat.more) begin
            state_next = S_PUSH;
          end
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        ctrl.push  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctrl.load_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/psp_datapath.sv */
// ----------------------------------------------------------------------------
// psp_datapath
// Span stack in a circular RAM, running min/max, best profit tracking and
// the result register.
// ----------------------------------------------------------------------------
module psp_datapath #(
  parameter int STACK_DEPTH = 1024,
  parameter int PRICE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  psp_pkg::ctrl_t               ctrl,
  output psp_pkg::stat_t               stat,
  input  logic [psp_pkg::FIELD_W-1:0]  price_in,
  output logic [psp_pkg::FIELD_W-1:0]  span_out,
  output logic [psp_pkg::FIELD_W-1:0]  profit_out,
  output logic [psp_pkg::FIELD_W-1:0]  buy_out,
  output logic [psp_pkg::FIELD_W-1:0]  sell_out,
  output logic                         trade_out,
  output logic [psp_pkg::FIELD_W-1:0]  lowest_out,
  output logic [psp_pkg::FIELD_W-1:0]  highest_out,
  output logic                         overflow_out
);
  import psp_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = PRICE_WIDTH + FIELD_W;
  localparam logic [AW-1:0] LAST = AW'(STACK_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  logic [AW-1:0]          tp;
  logic [CW-1:0]          count;
  logic [PRICE_WIDTH-1:0] p;
  logic [FIELD_W-1:0]     span;
  logic [PRICE_WIDTH-1:0] min_seen;
  logic [FIELD_W-1:0]     min_day;
  logic [PRICE_WIDTH-1:0] max_seen;
  logic [PRICE_WIDTH-1:0] profit_best;
  logic [FIELD_W-1:0]     best_buy;
  logic [FIELD_W-1:0]     best_sell;
  logic                   have_trade;
  logic [FIELD_W-1:0]     day_counter;
  logic                   overflow_seen;

  logic [AW-1:0]          tp_m1;
  logic [AW-1:0]          tp_m2;
  logic [AW-1:0]          tp_p1;
  logic [AW-1:0]          raddr;
  logic [EW-1:0]          rdata;
  logic [PRICE_WIDTH-1:0] top_price;
  logic [FIELD_W-1:0]     top_span;
  logic [FIELD_W:0]       span_sum;
  logic                   full;
  logic                   p_lt;
  logic [PRICE_WIDTH-1:0] min_new;
  logic [FIELD_W-1:0]     min_day_new;
  logic [PRICE_WIDTH-1:0] gain;

  assign tp_m1 = (tp == '0) ? LAST : tp - 1'b1;
  assign tp_m2 = (tp_m1 == '0) ? LAST : tp_m1 - 1'b1;
  assign tp_p1 = (tp == LAST) ? '0 : tp + 1'b1;
  assign raddr = ctrl.pop ? tp_m2 : tp_m1;

  psp_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ctrl.push),
    .waddr (tp),
    .wdata ({p, span}),
    .re    (ctrl.rd_top | ctrl.pop),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign top_price = rdata[EW-1:FIELD_W];
  assign top_span  = rdata[FIELD_W-1:0];
  assign span_sum  = {1'b0, span} + {1'b0, top_span};
  assign full      = (count == FULL);

  assign stat.empty  = (count == '0);
  assign stat.top_le = (top_price <= p);
  assign stat.more   = (count > CW'(1));

  assign p_lt        = (p < min_seen);
  assign min_new     = p_lt ? p : min_seen;
  assign min_day_new = p_lt ? day_counter : min_day;
  assign gain        = p - min_new;

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      p    <= PRICE_WIDTH'(price_in);
      span <= FIELD_W'(1);
    end else if (ctrl.pop) begin
      span <= span_sum[FIELD_W] ? '1 : span_sum[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tp            <= '0;
      count         <= '0;
      min_seen      <= '1;
      min_day       <= '0;
      max_seen      <= '0;
      profit_best   <= '0;
      best_buy      <= '0;
      best_sell     <= '0;
      have_trade    <= 1'b0;
      day_counter   <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (ctrl.pop) begin
        tp    <= tp_m1;
        count <= count - 1'b1;
      end
      if (ctrl.push) begin
        tp <= tp_p1;
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
        min_seen <= min_new;
        min_day  <= min_day_new;
        if (gain > profit_best) begin
          profit_best <= gain;
          best_buy    <= min_day_new;
          best_sell   <= day_counter;
          have_trade  <= 1'b1;
        end
        if (p > max_seen) begin
          max_seen <= p;
        end
        if (day_counter != '1) begin
          day_counter <= day_counter + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      span_out     <= span;
      profit_out   <= FIELD_W'(profit_best);
      buy_out      <= best_buy;
      sell_out     <= best_sell;
      trade_out    <= have_trade;
      lowest_out   <= FIELD_W'(min_seen);
      highest_out  <= FIELD_W'(max_seen);
      overflow_out <= overflow_seen;
    end
  end

endmodule

/* tb/price_span_profit_tracker_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// price_span_profit_tracker_unit_tb
// Streams prices into the tracker and checks every result against a local
// span-stack and profit predictor. Covers the price extremes, repeated and
// monotonic runs, a long descending run cleared by a top price, a long result
// stall and randomized idling on both channels.
// ----------------------------------------------------------------------------
module price_span_profit_tracker_unit_tb;
  import psp_pkg::*;

  localparam int SPAN_DEPTH  = 1024;
  localparam int WATCH_LIMIT = 20000;
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 400;

  typedef logic [FIELD_W-1:0] word_t;

  typedef struct {
    word_t span;
    word_t best_profit;
    word_t buy_day;
    word_t sell_day;
    logic  trade_found;
    word_t lowest_price;
    word_t highest_price;
    logic  stack_overflowed;
  } day_stats_t;

  typedef enum {PICK_WIDE, PICK_NARROW, PICK_WALK, PICK_EDGE} price_pattern_t;

  class tracker_scoreboard;
    word_t       span_price[SPAN_DEPTH];
    word_t       span_len[SPAN_DEPTH];
    int unsigned span_depth;
    word_t       low_price;
    word_t       low_day;
    word_t       high_price;
    word_t       profit;
    word_t       buy_at;
    word_t       sell_at;
    word_t       day_index;
    bit          traded;
    bit          overflowed;
    day_stats_t  pending_stats[$];
    int unsigned failures;
    int unsigned results_seen;

    function new();
      span_depth   = 0;
      low_price    = '1;
      low_day      = '0;
      high_price   = '0;
      profit       = '0;
      buy_at       = '0;
      sell_at      = '0;
      day_index    = '0;
      traded       = 1'b0;
      overflowed   = 1'b0;
      failures     = 0;
      results_seen = 0;
    endfunction

    function void note_price(word_t p);
      day_stats_t       s;
      word_t            run;
      word_t            today;
      logic [FIELD_W:0] sum;
      run   = 1;
      today = day_index;
      while (span_depth > 0 && span_price[span_depth-1] <= p) begin
        sum = {1'b0, run} + {1'b0, span_len[span_depth-1]};
        run = sum[FIELD_W] ? '1 : sum[FIELD_W-1:0];
        span_depth--;
      end
      if (span_depth >= SPAN_DEPTH) begin
        for (int i = 0; i < SPAN_DEPTH - 1; i++) begin
          span_price[i] = span_price[i+1];
          span_len[i]   = span_len[i+1];
        end
        span_depth = SPAN_DEPTH - 1;
        overflowed = 1'b1;
      end
      span_price[span_depth] = p;
      span_len[span_depth]   = run;
      span_depth++;

      if (p < low_price) begin
        low_price = p;
        low_day   = today;
      end
      if (p - low_price > profit) begin
        profit  = p - low_price;
        buy_at  = low_day;
        sell_at = today;
        traded  = 1'b1;
      end
      if (p > high_price)
        high_price = p;
      if (day_index != '1)
        day_index++;

      s.span             = run;
      s.best_profit      = profit;
      s.buy_day          = buy_at;
      s.sell_day         = sell_at;
      s.trade_found      = traded;
      s.lowest_price     = low_price;
      s.highest_price    = high_price;
      s.stack_overflowed = overflowed;
      pending_stats.push_back(s);
    endfunction

    function void compare_field(string name, word_t want, word_t got);
      if (want !== got) begin
        $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(day_stats_t got);
      day_stats_t want;
      results_seen++;
      if (pending_stats.size() == 0) begin
        $error("result item with no price pending");
        failures++;
        return;
      end
      want = pending_stats.pop_front();
      compare_field("span", want.span, got.span);
      compare_field("best_profit", want.best_profit, got.best_profit);
      compare_field("buy_day", want.buy_day, got.buy_day);
      compare_field("sell_day", want.sell_day, got.sell_day);
      compare_field("trade_found", word_t'(want.trade_found), word_t'(got.trade_found));
      compare_field("lowest_price", want.lowest_price, got.lowest_price);
      compare_field("highest_price", want.highest_price, got.highest_price);
      compare_field("stack_overflowed", word_t'(want.stack_overflowed),
                    word_t'(got.stack_overflowed));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  psp_in_if  prices();
  psp_out_if results();

  price_span_profit_tracker_unit #(
    .STACK_DEPTH (SPAN_DEPTH),
    .PRICE_WIDTH (FIELD_W)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .prices  (prices),
    .results (results)
  );

  tracker_scoreboard board = new();

  int send_idle   = 0;
  int recv_idle   = 0;
  int hold_left   = 0;
  int quiet_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    day_stats_t got;
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        got.span             = results.span;
        got.best_profit      = results.best_profit;
        got.buy_day          = results.buy_day;
        got.sell_day         = results.sell_day;
        got.trade_found      = results.trade_found;
        got.lowest_price     = results.lowest_price;
        got.highest_price    = results.highest_price;
        got.stack_overflowed = results.stack_overflowed;
        board.check_result(got);
        if (board.results_seen == HOLD_AT)
          hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        results.ready <= 1'b0;
      end else begin
        results.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (prices.valid && prices.ready) || (results.valid && results.ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCH_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  task automatic send_price(input word_t p);
    while ($urandom_range(99) < send_idle) begin
      prices.valid <= 1'b0;
      @(posedge clk);
    end
    prices.valid <= 1'b1;
    prices.price <= p;
    do @(posedge clk); while (!prices.ready);
    board.note_price(p);
  endtask

  task automatic wait_drained();
    prices.valid <= 1'b0;
    do @(posedge clk); while (board.pending_stats.size() != 0);
  endtask

  task automatic run_random(input int count);
    price_pattern_t pattern;
    int             burst;
    word_t          p;
    burst   = 0;
    pattern = PICK_WIDE;
    p       = $urandom;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        pattern = price_pattern_t'($urandom_range(3));
        burst   = $urandom_range(4, 30);
      end
      burst--;
      case (pattern)
        PICK_WIDE:   p = $urandom;
        PICK_NARROW: p = $urandom_range(15);
        PICK_WALK:   p = p + word_t'($urandom_range(200)) - word_t'(100);
        PICK_EDGE: begin
          case ($urandom_range(3))
            0:       p = '0;
            1:       p = '1;
            2:       p = 32'h8000_0000;
            default: p = 32'h7FFF_FFFF;
          endcase
        end
        default:     p = $urandom;
      endcase
      send_price(p);
    end
  endtask

  // push a long falling run, then pop it with a top price
  task automatic fill_stack(input int count);
    word_t p;
    p = 32'hF000_0000;
    repeat (count) begin
      send_price(p);
      p = p - word_t'($urandom_range(1, 1000));
    end
    send_price('1);
  endtask

  word_t opening_prices[] = '{
    32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001,
    32'h0000_0001, 32'h0000_0005, 32'h0000_0004, 32'h0000_0003, 32'h0000_0002,
    32'h0000_0006, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFE,
    32'h0000_0010, 32'h0000_0020, 32'h0000_0030, 32'h0000_0025, 32'h0000_0040
  };

  initial begin
    prices.valid  = 1'b0;
    prices.price  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_idle = 33;
    recv_idle = 84;
    foreach (opening_prices[i])
      send_price(opening_prices[i]);
    run_random(120);
    wait_drained();

    send_idle = 84;
    recv_idle = 33;
    run_random(120);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    fill_stack(60);
    run_random(130);
    wait_drained();

    repeat (20) @(posedge clk);
    if (board.failures == 0 && board.pending_stats.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
sv/psp_pkg.sv
sv/psp_in_if.sv
sv/psp_out_if.sv
sv/psp_ram.sv
sv/psp_ctrl.sv
sv/psp_datapath.sv
sv/price_span_profit_tracker_unit.sv
tb/price_span_profit_tracker_unit_tb.sv
